/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the velocity estimator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define PVE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a consequence at the next edge.
`define PVE_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define PVE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PVE_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif
`endif

/* hw/rtl/pve_pkg.sv */
// Shared types and constants of the position velocity estimator.
// No dependencies; imported by every module of the block.
`default_nettype none

package pve_pkg;

  localparam int unsigned POS_DEPTH_DEFAULT = 16;
  localparam int unsigned VEL_DEPTH_DEFAULT = 16;
  localparam logic [31:0] SCALE_RESET       = 32'h0001_0000;

  // item operation codes
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_PRELOAD = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // per-item control carried along the pipeline
  typedef struct packed {
    logic valid;
    logic sample;
    logic hist_clr;
    logic sat;
  } pve_tag_t;

endpackage

`default_nettype wire

/* hw/rtl/pve_pos_stage.sv */
// Input register, position ring, difference to the oldest position and scale multiply.
// Depends on pve_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pve_pos_stage #(
  parameter int unsigned POSITION_DEPTH = pve_pkg::POS_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] position_i,
  input  logic [31:0]        scale_i,
  output pve_pkg::pve_tag_t  tag_o,
  output logic [63:0]        prod_o,
  output logic               neg_o
);
  import pve_pkg::*;

  localparam int unsigned SlotW = $clog2(POSITION_DEPTH);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(POSITION_DEPTH - 1);

  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
    if (s == LastSlot) begin
      return '0;
    end
    return s + SlotW'(1);
  endfunction

  logic               s1_valid_q;
  logic [1:0]         s1_op_q;
  logic [31:0]        s1_pos_q;

  logic [31:0]        pos_mem_q [POSITION_DEPTH];
  logic [31:0]        rd_q;
  logic               rd_valid_q;
  logic [POSITION_DEPTH-1:0] pvalid_q, pvalid_d;
  logic [31:0]        fill_q, fill_d;
  logic [SlotW-1:0]   pslot_q, pslot_d;
  logic [SlotW-1:0]   raddr;
  logic               pwr;
  logic               fwd;
  logic               do_step;

  logic [31:0]        oldest;
  logic [32:0]        diff;
  logic [32:0]        diff_neg;
  logic [31:0]        mag;
  logic [63:0]        prod_d;

  pve_tag_t           tag_q, tag_d;
  logic [63:0]        prod_q;
  logic               neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_op_q  <= op_i;
      s1_pos_q <= position_i;
    end
  end

  assign do_step = adv_i && s1_valid_q;

  always_comb begin
    pslot_d  = pslot_q;
    pvalid_d = pvalid_q;
    fill_d   = fill_q;
    pwr      = 1'b0;
    if (do_step) begin
      case (s1_op_q)
        OP_SAMPLE: begin
          pwr               = 1'b1;
          pvalid_d[pslot_q] = 1'b1;
          pslot_d           = slot_next(pslot_q);
        end
        OP_PRELOAD: begin
          pvalid_d = '0;
          fill_d   = s1_pos_q;
          pslot_d  = '0;
        end
        OP_CLEAR: begin
          pvalid_d = '0;
          fill_d   = '0;
          pslot_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // prefetch the oldest entry for the item that follows
  assign raddr = slot_next(pslot_d);
  assign fwd   = pwr && (pslot_q == raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pslot_q    <= '0;
      pvalid_q   <= '0;
      fill_q     <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      pslot_q    <= pslot_d;
      pvalid_q   <= pvalid_d;
      fill_q     <= fill_d;
      rd_valid_q <= pvalid_d[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwr) begin
      pos_mem_q[pslot_q] <= s1_pos_q;
    end
    rd_q <= fwd ? s1_pos_q : pos_mem_q[raddr];
  end

  assign oldest   = rd_valid_q ? rd_q : fill_q;
  assign diff     = {s1_pos_q[31], s1_pos_q} - {oldest[31], oldest};
  assign diff_neg = -diff;
  assign mag      = diff[32] ? diff_neg[31:0] : diff[31:0];
  assign prod_d   = mag * scale_i;

  always_comb begin
    tag_d          = '0;
    tag_d.valid    = s1_valid_q;
    tag_d.sample   = (s1_op_q == OP_SAMPLE);
    tag_d.hist_clr = (s1_op_q == OP_PRELOAD) || (s1_op_q == OP_CLEAR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv_i) begin
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      neg_q  <= diff[32];
    end
  end

  assign tag_o  = tag_q;
  assign prod_o = prod_q;
  assign neg_o  = neg_q;

  `PVE_ASSERT(a_pslot_range, clk_i, rst_ni, pslot_q <= LastSlot, "position slot out of range")
  `PVE_ASSERT_NEXT(a_pslot_rewind, clk_i, rst_ni, do_step && (s1_op_q == OP_PRELOAD || s1_op_q == OP_CLEAR), pslot_q == '0 && pvalid_q == '0, "position ring not rewound")

endmodule

`default_nettype wire

/* hw/rtl/pve_vel_stage.sv */
// Velocity saturation, velocity ring and running sum with a bias for the divider.
// Depends on pve_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pve_vel_stage #(
  parameter int unsigned VELOCITY_DEPTH = pve_pkg::VEL_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  pve_pkg::pve_tag_t                   tag_i,
  input  logic [63:0]                         prod_i,
  input  logic                                neg_i,
  output pve_pkg::pve_tag_t                   tag_o,
  output logic [31+$clog2(VELOCITY_DEPTH):0]  ubias_o
);
  import pve_pkg::*;

  localparam int unsigned SumW  = 32 + $clog2(VELOCITY_DEPTH);
  localparam int unsigned SlotW = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(VELOCITY_DEPTH - 1);
  // offset that makes the sum non-negative: depth times 2^31
  localparam logic [SumW:0] Bias = (SumW + 1)'(VELOCITY_DEPTH) << 31;

  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
    if (s == LastSlot) begin
      return '0;
    end
    return s + SlotW'(1);
  endfunction

  logic [47:0]              scaled;
  logic [47:0]              lim;
  logic                     sat;
  logic [31:0]              clip;
  logic signed [31:0]       raw;
  logic signed [31:0]       old;
  logic                     do_step;

  logic [31:0]              vmem_q [VELOCITY_DEPTH];
  logic [31:0]              vrd_q;
  logic                     vrd_valid_q;
  logic [VELOCITY_DEPTH-1:0] vvalid_q, vvalid_d;
  logic [SlotW-1:0]         vslot_q, vslot_d;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic                     vwr;
  logic                     fwd;
  logic [SumW:0]            sum_ext;

  pve_tag_t                 tag_q, tag_d;
  logic [SumW-1:0]          ubias_q;

  assign scaled = prod_i[63:16];
  assign lim    = neg_i ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
  assign sat    = scaled > lim;
  assign clip   = sat ? lim[31:0] : scaled[31:0];
  assign raw    = neg_i ? -clip : clip;
  assign old    = vrd_valid_q ? vrd_q : '0;

  assign do_step = adv_i && tag_i.valid;

  always_comb begin
    vslot_d  = vslot_q;
    vvalid_d = vvalid_q;
    sum_d    = sum_q;
    vwr      = 1'b0;
    if (do_step && tag_i.sample) begin
      vwr               = 1'b1;
      vvalid_d[vslot_q] = 1'b1;
      vslot_d           = slot_next(vslot_q);
      sum_d             = sum_q - SumW'(old) + SumW'(raw);
    end else if (do_step && tag_i.hist_clr) begin
      vvalid_d = '0;
      vslot_d  = '0;
      sum_d    = '0;
    end
  end

  // prefetch the entry that the next sample overwrites
  assign fwd = vwr && (vslot_q == vslot_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vslot_q     <= '0;
      vvalid_q    <= '0;
      sum_q       <= '0;
      vrd_valid_q <= 1'b0;
    end else begin
      vslot_q     <= vslot_d;
      vvalid_q    <= vvalid_d;
      sum_q       <= sum_d;
      vrd_valid_q <= vvalid_d[vslot_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwr) begin
      vmem_q[vslot_q] <= raw;
    end
    vrd_q <= fwd ? raw : vmem_q[vslot_d];
  end

  assign sum_ext = (SumW + 1)'(sum_d);

  always_comb begin
    tag_d     = tag_i;
    tag_d.sat = tag_i.sample && sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv_i) begin
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ubias_q <= SumW'(sum_ext + Bias);
    end
  end

  assign tag_o   = tag_q;
  assign ubias_o = ubias_q;

  `PVE_ASSERT(a_vslot_range, clk_i, rst_ni, vslot_q <= LastSlot, "velocity slot out of range")
  `PVE_ASSERT_NEXT(a_hist_cleared, clk_i, rst_ni, do_step && tag_i.hist_clr, sum_q == '0 && !vrd_valid_q, "velocity history not cleared")

endmodule

`default_nettype wire

/* hw/rtl/pve_div.sv */
// Floor division of the biased velocity sum by the velocity ring depth.
// A shift for power-of-two depths, else a long division eight bits per stage.
// Depends on pve_pkg.
`default_nettype none

module pve_div #(
  parameter int unsigned VELOCITY_DEPTH = pve_pkg::VEL_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  pve_pkg::pve_tag_t                   tag_i,
  input  logic [31+$clog2(VELOCITY_DEPTH):0]  ubias_i,
  output pve_pkg::pve_tag_t                   tag_o,
  output logic [31:0]                         quot_o
);
  import pve_pkg::*;

  localparam int unsigned SumW   = 32 + $clog2(VELOCITY_DEPTH);
  localparam bit          IsPow2 = (VELOCITY_DEPTH & (VELOCITY_DEPTH - 1)) == 0;

  if (IsPow2) begin : g_shift
    localparam int unsigned Log2 = $clog2(VELOCITY_DEPTH);
    pve_tag_t    tag_q;
    logic [31:0] quot_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q <= '0;
      end else if (adv_i) begin
        tag_q <= tag_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quot_q <= 32'(ubias_i >> Log2);
      end
    end

    assign tag_o  = tag_q;
    assign quot_o = quot_q;
  end else begin : g_long
    localparam int unsigned Stages = (SumW + 7) / 8;
    localparam int unsigned WorkW  = Stages * 8;
    localparam int unsigned RemW   = $clog2(VELOCITY_DEPTH) + 1;
    localparam logic [RemW:0] Divisor = (RemW + 1)'(VELOCITY_DEPTH);

    // dividend bits leave at the top of work, quotient bits enter at the bottom
    typedef struct packed {
      logic [WorkW-1:0] work;
      logic [RemW-1:0]  rem;
    } div_st_t;

    function automatic div_st_t step8(input div_st_t st_in);
      div_st_t     s;
      logic [RemW:0] t;
      logic        ge;
      s = st_in;
      for (int j = 0; j < 8; j++) begin
        t      = {s.rem, s.work[WorkW-1]};
        ge     = (t >= Divisor);
        s.work = {s.work[WorkW-2:0], ge};
        s.rem  = ge ? RemW'(t - Divisor) : t[RemW-1:0];
      end
      return s;
    endfunction

    div_st_t  st_q  [Stages];
    pve_tag_t tag_q [Stages];

    for (genvar g = 0; g < Stages; g++) begin : g_stage
      div_st_t  st_in;
      pve_tag_t tag_in;

      if (g == 0) begin : g_first
        assign st_in  = {WorkW'(ubias_i), RemW'(0)};
        assign tag_in = tag_i;
      end else begin : g_rest
        assign st_in  = st_q[g-1];
        assign tag_in = tag_q[g-1];
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          tag_q[g] <= '0;
        end else if (adv_i) begin
          tag_q[g] <= tag_in;
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          st_q[g] <= step8(st_in);
        end
      end
    end

    assign tag_o  = tag_q[Stages-1];
    assign quot_o = st_q[Stages-1].work[31:0];
  end

endmodule

`default_nettype wire

/* hw/rtl/position_velocity_estimator.sv */
// Top level of the position velocity estimator: scale register, pipeline control
// and output register. Depends on pve_pkg, pve_pos_stage, pve_vel_stage, pve_div.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, op_i, position_i): a transfer happens
//   on a rising edge with in_valid_i high and in_stall_o low. op_i selects a
//   position sample, a preload of the position ring, or a clear of all history.
//   Output channel (out_valid_o, out_stall_i, velocity_o, saturated_o): one
//   result per input item, in order. Preload, clear and unused codes give zero.
//   Configuration: cfg_we_i writes cfg_wdata_i into the Q16.16 velocity scale.
//   Throughput: one item per clock while out_stall_i does not hold the
//   pipeline. An item passes through the input, product and sum registers,
//   the divider stages and the output register on its way to out_valid_o.
//   Reset: both rings read as zero, sums and slots are zero, scale is 1.0, no
//   result is pending.
//   Stall: while a result waits and out_stall_i is high, the whole pipeline
//   holds and in_stall_o is raised in the same cycle.
`default_nettype none

module position_velocity_estimator #(
  parameter int unsigned POSITION_DEPTH = pve_pkg::POS_DEPTH_DEFAULT,
  parameter int unsigned VELOCITY_DEPTH = pve_pkg::VEL_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] velocity_o,
  output logic               saturated_o
);
  import pve_pkg::*;

  localparam int unsigned SumW = 32 + $clog2(VELOCITY_DEPTH);

  logic [31:0]     scale_q;
  logic            adv;
  pve_tag_t        pos_tag;
  logic [63:0]     prod;
  logic            neg;
  pve_tag_t        vel_tag;
  logic [SumW-1:0] ubias;
  pve_tag_t        div_tag;
  logic [31:0]     quot;

  logic            out_valid_q;
  logic [31:0]     velocity_q;
  logic            sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // advance everything unless a held result is stalled
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  pve_pos_stage #(
    .POSITION_DEPTH(POSITION_DEPTH)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .position_i (position_i),
    .scale_i    (scale_q),
    .tag_o      (pos_tag),
    .prod_o     (prod),
    .neg_o      (neg)
  );

  pve_vel_stage #(
    .VELOCITY_DEPTH(VELOCITY_DEPTH)
  ) u_vel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .tag_i   (pos_tag),
    .prod_i  (prod),
    .neg_i   (neg),
    .tag_o   (vel_tag),
    .ubias_o (ubias)
  );

  pve_div #(
    .VELOCITY_DEPTH(VELOCITY_DEPTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .tag_i   (vel_tag),
    .ubias_i (ubias),
    .tag_o   (div_tag),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_tag.valid;
    end
  end

  // drop the bias by flipping the top bit of the quotient
  always_ff @(posedge clk_i) begin
    if (adv) begin
      velocity_q <= div_tag.sample ? (quot ^ 32'h8000_0000) : '0;
      sat_q      <= div_tag.sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign velocity_o  = velocity_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

/* verif/tb_position_velocity_estimator.sv */
`timescale 1ns / 1ps
// Self-checking testbench of position_velocity_estimator: directed and random items
// with random idling on both channels, checked against a predictor in a scoreboard.
// Depends on pve_pkg and the position_velocity_estimator RTL.

typedef struct {
  logic signed [31:0] velocity;
  logic               saturated;
} velocity_result_t;

class velocity_scoreboard;
  localparam int unsigned POS_DEPTH = pve_pkg::POS_DEPTH_DEFAULT;
  localparam int unsigned VEL_DEPTH = pve_pkg::VEL_DEPTH_DEFAULT;
  localparam int unsigned VEL_SHIFT = $clog2(VEL_DEPTH);

  longint           pos_ring [POS_DEPTH];
  longint           vel_ring [VEL_DEPTH];
  longint           vel_sum;
  int unsigned      pos_slot;
  int unsigned      vel_slot;
  logic [31:0]      scale;
  velocity_result_t expected_velocities [$];
  int               errors;

  function new();
    foreach (pos_ring[i]) pos_ring[i] = 0;
    clear_velocity_history();
    pos_slot = 0;
    scale    = pve_pkg::SCALE_RESET;
    errors   = 0;
  endfunction

  function void clear_velocity_history();
    foreach (vel_ring[i]) vel_ring[i] = 0;
    vel_sum  = 0;
    vel_slot = 0;
  endfunction

  function void set_scale(logic [31:0] value);
    scale = value;
  endfunction

  function int pending();
    return expected_velocities.size();
  endfunction

  // Advance the predictor by one accepted item and queue its result.
  function void note_position_item(logic [1:0] op, logic signed [31:0] pos);
    int unsigned      nxt_slot;
    longint           diff;
    longint           raw;
    bit [63:0]        mag;
    bit [63:0]        scaled;
    velocity_result_t res;
    res.velocity  = '0;
    res.saturated = 1'b0;
    case (op)
      pve_pkg::OP_PRELOAD: begin
        foreach (pos_ring[i]) pos_ring[i] = longint'(pos);
        pos_slot = 0;
        clear_velocity_history();
      end
      pve_pkg::OP_CLEAR: begin
        foreach (pos_ring[i]) pos_ring[i] = 0;
        pos_slot = 0;
        clear_velocity_history();
      end
      pve_pkg::OP_SAMPLE: begin
        nxt_slot           = (pos_slot + 1) % POS_DEPTH;
        pos_ring[pos_slot] = longint'(pos);
        diff               = longint'(pos) - pos_ring[nxt_slot];
        pos_slot           = nxt_slot;
        mag                = (diff < 0) ? -diff : diff;
        scaled             = (mag * {32'd0, scale}) >> 16;
        if (diff < 0) begin
          if (scaled > 64'h8000_0000) begin
            scaled        = 64'h8000_0000;
            res.saturated = 1'b1;
          end
          raw = -longint'(scaled);
        end else begin
          if (scaled > 64'h7FFF_FFFF) begin
            scaled        = 64'h7FFF_FFFF;
            res.saturated = 1'b1;
          end
          raw = longint'(scaled);
        end
        vel_sum            = vel_sum - vel_ring[vel_slot] + raw;
        vel_ring[vel_slot] = raw;
        vel_slot           = (vel_slot + 1) % VEL_DEPTH;
        // floor of the average: arithmetic shift for a power-of-two depth
        res.velocity       = 32'(vel_sum >>> VEL_SHIFT);
      end
      default: ;
    endcase
    expected_velocities.push_back(res);
  endfunction

  function void check_velocity(logic signed [31:0] vel, logic sat);
    velocity_result_t exp_res;
    if (expected_velocities.size() == 0) begin
      $error("result with nothing expected: velocity %0d saturated %0b", vel, sat);
      errors++;
      return;
    end
    exp_res = expected_velocities.pop_front();
    if (vel !== exp_res.velocity) begin
      $error("velocity: expected %0d, actual %0d", exp_res.velocity, vel);
      errors++;
    end
    if (sat !== exp_res.saturated) begin
      $error("saturated: expected %0b, actual %0b", exp_res.saturated, sat);
      errors++;
    end
  endfunction
endclass

module tb_position_velocity_estimator;
  import pve_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         SETTLE_CYCLES  = 10;
  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         PHASE_ITEMS    = 200;
  localparam int         NUM_PHASES     = 6;
  localparam int         LONG_HOLD      = 400;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i        = OP_SAMPLE;
  logic signed [31:0] position_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] velocity_o;
  logic               saturated_o;

  velocity_scoreboard vel_sb;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_request  = 0;
  int                 hold_left     = 0;
  int                 cycle_count   = 0;
  logic signed [31:0] track_pos     = '0;

  position_velocity_estimator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .velocity_o  (velocity_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Observe every transfer and register write at the edge it happens on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) vel_sb.set_scale(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) vel_sb.note_position_item(op_i, position_i);
      if (out_valid_o && !out_stall_i) vel_sb.check_velocity(velocity_o, saturated_o);
    end
  end

  task automatic send_item(logic [1:0] op, logic signed [31:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    position_i <= pos;
    @(posedge clk_i);
    // hold the payload until the transfer
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Wait for an edge first so the last transfer is already in the scoreboard.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (vel_sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly a moving axis with random speed; some wild samples, preloads, clears, unused codes.
  task automatic send_random_item();
    int          kind;
    int unsigned width;
    logic [31:0] step;
    kind = $urandom_range(99);
    if (kind < 78) begin
      width = $urandom_range(30, 0);
      step  = $urandom & ((32'h1 << width) - 1);
      if ($urandom_range(1)) step = -step;
      track_pos = track_pos + step;
      send_item(OP_SAMPLE, track_pos);
    end else if (kind < 88) begin
      send_item(OP_SAMPLE, $urandom);
    end else if (kind < 93) begin
      track_pos = $urandom_range(1) ? $urandom : track_pos;
      send_item(OP_PRELOAD, track_pos);
    end else if (kind < 97) begin
      track_pos = '0;
      send_item(OP_CLEAR, $urandom);
    end else begin
      send_item(OP_UNUSED, $urandom);
    end
  endtask

  initial begin
    logic [31:0] phase_scale [NUM_PHASES];
    vel_sb = new();
    phase_scale = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                    32'h0000_0001, 32'h0010_0000, 32'h0000_0000};
    phase_scale[5] = $urandom;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset scale of 1.0
    send_item(OP_SAMPLE,  32'sd0);
    send_item(OP_SAMPLE,  32'sh7FFF_FFFF);
    send_item(OP_SAMPLE,  32'sh8000_0000);
    send_item(OP_PRELOAD, 32'sh8000_0000);
    send_item(OP_SAMPLE,  32'sh7FFF_FFFF);     // full positive swing clips
    send_item(OP_PRELOAD, 32'sh7FFF_FFFF);
    send_item(OP_SAMPLE,  32'sh8000_0000);     // full negative swing clips
    send_item(OP_SAMPLE,  32'sh5555_5555);
    send_item(OP_UNUSED,  32'shAAAA_AAAA);     // unused code leaves state alone
    send_item(OP_CLEAR,   32'sh1234_5678);
    send_item(OP_SAMPLE,  -32'sd1);
    send_item(OP_PRELOAD, 32'sd0);
    send_item(OP_SAMPLE,  32'sh8000_0000);     // exactly -2^31 does not clip
    for (int k = 1; k <= 12; k++) send_item(OP_SAMPLE, k * 1000);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      write_scale(phase_scale[phase]);
      if (phase < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 59;
      end else if (phase < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) hold_request = LONG_HOLD;
        if (phase == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_random_item();
      end
    end

    drain_results();
    if (vel_sb.errors == 0 && vel_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
